FILE: design/irgar_pkg.sv
`default_nettype none

package irgar_pkg;

  // Calibration table size in bytes (16 .. 256)
  localparam int CAL_BYTES = 64;
  localparam int CAL_AW    = (CAL_BYTES > 1) ? $clog2(CAL_BYTES) : 1;
  // response length and byte position: up to header + table + one word of slack
  localparam int LEN_W     = $clog2(CAL_BYTES + 9);

  // request collector
  localparam int REQ_DEPTH = 6;
  localparam int REQ_AW    = $clog2(REQ_DEPTH);
  localparam int CNT_W     = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

  // input item kinds
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_DISC = 2'd2;

  // request packet types and lengths
  localparam logic [7:0]       PKT_STATUS = 8'h01;
  localparam logic [7:0]       PKT_CAL    = 8'h02;
  localparam logic [CNT_W-1:0] STATUS_LEN = 3'd3;
  localparam logic [CNT_W-1:0] CAL_LEN    = 3'd6;

  // response codes and constants
  localparam logic [7:0]  RESP_STATUS  = 8'h10;
  localparam logic [7:0]  RESP_CAL     = 8'h11;
  localparam logic [4:0]  BATTERY_FULL = 5'h1F;
  localparam logic [11:0] STICK_CENTER = 12'h800;
  localparam logic [15:0] ALIGN_MASK   = 16'hFFF0;
  localparam int          HDR_LEN      = 5;

  localparam logic [7:0] FACTORY_CAL [64] = '{
    8'h00, 8'h00, 8'h08, 8'h80, 8'h85, 8'hEB, 8'h11, 8'h3F,
    8'h85, 8'hEB, 8'h11, 8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hF5,
    8'hFF, 8'h00, 8'h08, 8'h80, 8'h85, 8'hEB, 8'h11, 8'h3F,
    8'h85, 8'hEB, 8'h11, 8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h65,
    8'hFF, 8'h00, 8'h08, 8'h80, 8'h85, 8'hEB, 8'h11, 8'h3F,
    8'h85, 8'hEB, 8'h11, 8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h65,
    8'hFF, 8'h00, 8'h08, 8'h80, 8'h85, 8'hEB, 8'h11, 8'h3F,
    8'h85, 8'hEB, 8'h11, 8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h65
  };

  // table entry i repeats factory byte i mod 64
  function automatic logic [7:0] cal_byte(input logic [CAL_AW-1:0] idx);
    logic [7:0] wide;
    wide = 8'(idx);
    return FACTORY_CAL[wide[5:0]];
  endfunction

endpackage

`default_nettype wire

FILE: design/irgar_if.sv
`default_nettype none

interface irgar_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         byte_value;
  logic               byte_last;
  logic signed [11:0] stick_x;
  logic signed [11:0] stick_y;
  logic               zl_pressed;
  logic               zr_pressed;

  modport source (
    output valid, req_type, byte_value, byte_last, stick_x, stick_y, zl_pressed, zr_pressed,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_value, byte_last, stick_x, stick_y, zl_pressed, zr_pressed,
    output ready
  );
endinterface

interface irgar_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_data;
  logic [2:0]  out_bytes;
  logic        out_last;

  modport source (output valid, out_data, out_bytes, out_last, input ready);
  modport sink   (input valid, out_data, out_bytes, out_last, output ready);
endinterface

`default_nettype wire

FILE: design/irgar_ram.sv
`default_nettype none

module irgar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/ir_gamepad_accessory_responder_unit.sv
`default_nettype none

// Accessory responder for an infrared controller link.
// req channel: one item per request byte, millisecond tick or disconnect.
//   Bytes are stored in a 6-entry request RAM; the byte marked last closes
//   the packet. ready is high only while the unit is idle.
// rsp channel: 32-bit little-endian words with a byte count and a last flag.
// Sequence:
//   plain request byte, tick without report, disconnect: handled in S_IDLE.
//   closing byte of a 3- or 6-byte packet: RAM readout of its bytes, then
//     drain, then decode; other lengths: the unit stays idle.
//   calibration reply: then ceil((5 + size) / 4) words, one per unstalled cycle.
//   status report: 2 words, one per unstalled cycle, the first from S_STAT0.
//   The readout rate is set by the single read port of the request RAM; the
//   reply rate by one word out per cycle while the receiver is ready.
// A registered output stage holds each word; while the receiver stalls a
//   reply the unit holds in its current state and takes no new request. The
//   last word of a reply may still wait there while new requests are taken.
// Reset (rst, synchronous): status reports stop, period and countdown clear,
//   the collector empties. The request RAM needs no clearing.
module ir_gamepad_accessory_responder_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  irgar_req_if.sink    req,
  irgar_rsp_if.source  rsp
);

  localparam int LW = irgar_pkg::LEN_W;
  localparam int CW = irgar_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DECODE,
    S_SEND,
    S_STAT0,
    S_STAT1
  } state_t;

  state_t state;

  logic [CW-1:0] count;
  logic [CW-1:0] pkt_count;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] rd_tag;
  logic          rd_pend;
  logic [7:0]    period;
  logic [7:0]    ticks;
  logic          enabled;
  logic [7:0]    pkt [irgar_pkg::REQ_DEPTH];
  logic [7:0]    ram_rdata;

  logic [LW-1:0] pos;
  logic [LW-1:0] len_r;
  logic [LW-1:0] offset_r;

  logic [31:0]   stat_word;
  logic [7:0]    stat_btn;

  logic          rsp_valid;
  logic [31:0]   rsp_data;
  logic [2:0]    rsp_bytes;
  logic          rsp_last;

  logic          accept;
  logic          out_free;
  logic          rsp_load;
  logic [CW-1:0] count_inc;
  logic          ram_we;

  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign rsp_load  = out_free && (state inside {S_SEND, S_STAT0, S_STAT1});
  assign count_inc = (count == irgar_pkg::CNT_MAX) ? count : CW'(count + 1'b1);
  assign ram_we    = accept && (req.req_type == irgar_pkg::REQ_BYTE) &&
                     (count < CW'(irgar_pkg::REQ_DEPTH));

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.out_data  = rsp_data;
  assign rsp.out_bytes = rsp_bytes;
  assign rsp.out_last  = rsp_last;

  irgar_ram #(
    .WIDTH (8),
    .DEPTH (irgar_pkg::REQ_DEPTH)
  ) u_req_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[irgar_pkg::REQ_AW-1:0]),
    .wdata (req.byte_value),
    .re    (state == S_READ),
    .raddr (rd_idx[irgar_pkg::REQ_AW-1:0]),
    .rdata (ram_rdata)
  );

  // decode of the collected packet
  logic [15:0] off16;
  logic [15:0] sz16;
  logic [16:0] span;
  logic        cal_ok;

  assign off16  = {pkt[3], pkt[2]} & irgar_pkg::ALIGN_MASK;
  assign sz16   = {pkt[5], pkt[4]} & irgar_pkg::ALIGN_MASK;
  assign span   = {1'b0, off16} + {1'b0, sz16};
  assign cal_ok = (pkt[0] == irgar_pkg::PKT_CAL) && (pkt_count == irgar_pkg::CAL_LEN) &&
                  (span <= 17'(irgar_pkg::CAL_BYTES));

  // calibration reply word at byte position pos
  logic [LW-1:0] remaining;
  logic [2:0]    send_n;
  logic          send_last;
  logic [7:0]    sb [4];
  logic [31:0]   send_word;

  assign remaining = LW'(len_r - pos);
  assign send_last = (remaining <= LW'(4));
  assign send_n    = send_last ? remaining[2:0] : 3'd4;

  always_comb begin
    logic [LW-1:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx   = LW'(offset_r + pos + LW'(k) - LW'(irgar_pkg::HDR_LEN));
      sb[k] = irgar_pkg::cal_byte(idx[irgar_pkg::CAL_AW-1:0]);
    end
    if (pos == '0) begin
      sb[0] = irgar_pkg::RESP_CAL;
      sb[1] = pkt[2];
      sb[2] = pkt[3];
      sb[3] = pkt[4];
    end else if (pos == LW'(4)) begin
      sb[0] = pkt[5];
    end
    for (int k = 0; k < 4; k++) begin
      if (3'(k) >= send_n) begin
        sb[k] = 8'h00;
      end
    end
    send_word = {sb[3], sb[2], sb[1], sb[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      period    <= '0;
      ticks     <= '0;
      enabled   <= 1'b0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      rd_tag  <= rd_idx;
      if (rd_pend) begin
        pkt[rd_tag[irgar_pkg::REQ_AW-1:0]] <= ram_rdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            case (req.req_type)
              irgar_pkg::REQ_BYTE: begin
                if (req.byte_last) begin
                  count     <= '0;
                  pkt_count <= count_inc;
                  rd_idx    <= '0;
                  if (count_inc == irgar_pkg::STATUS_LEN || count_inc == irgar_pkg::CAL_LEN) begin
                    state <= S_READ;
                  end
                end else begin
                  count <= count_inc;
                end
              end
              irgar_pkg::REQ_TICK: begin
                if (enabled) begin
                  if (ticks <= 8'd1) begin
                    ticks     <= period;
                    stat_word <= {12'(irgar_pkg::STICK_CENTER + $unsigned(req.stick_y)),
                                  12'(irgar_pkg::STICK_CENTER + $unsigned(req.stick_x)),
                                  irgar_pkg::RESP_STATUS};
                    stat_btn  <= {1'b1, ~req.zr_pressed, ~req.zl_pressed,
                                  irgar_pkg::BATTERY_FULL};
                    state     <= S_STAT0;
                  end else begin
                    ticks <= ticks - 8'd1;
                  end
                end
              end
              irgar_pkg::REQ_DISC: begin
                enabled <= 1'b0;
              end
              default: ;
            endcase
          end
        end

        S_READ: begin
          rd_idx <= CW'(rd_idx + 1'b1);
          if (rd_idx == CW'(pkt_count - 1'b1)) begin
            state <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          state <= S_DECODE;
        end

        S_DECODE: begin
          if (pkt[0] == irgar_pkg::PKT_STATUS && pkt_count == irgar_pkg::STATUS_LEN) begin
            period  <= pkt[1];
            ticks   <= pkt[1];
            enabled <= 1'b1;
            state   <= S_IDLE;
          end else if (cal_ok) begin
            offset_r <= LW'(off16);
            len_r    <= LW'(sz16 + 16'(irgar_pkg::HDR_LEN));
            pos      <= '0;
            state    <= S_SEND;
          end else begin
            state <= S_IDLE;
          end
        end

        S_SEND: begin
          if (out_free) begin
            rsp_data  <= send_word;
            rsp_bytes <= send_n;
            rsp_last  <= send_last;
            pos       <= LW'(pos + LW'(4));
            if (send_last) begin
              state <= S_IDLE;
            end
          end
        end

        S_STAT0: begin
          if (out_free) begin
            rsp_data  <= stat_word;
            rsp_bytes <= 3'd4;
            rsp_last  <= 1'b0;
            state     <= S_STAT1;
          end
        end

        S_STAT1: begin
          if (out_free) begin
            rsp_data  <= {24'h0, stat_btn};
            rsp_bytes <= 3'd2;
            rsp_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a status report only starts while reports are enabled
  a_stat_enabled: assert property (@(posedge clk) disable iff (rst)
    (state == S_STAT0) |-> enabled)
    else $error("status report while disabled");

  // reply position never runs past the reply length
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> (pos < len_r))
    else $error("reply position overrun");

  // a RAM capture always follows a readout cycle
  a_rd_after_read: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(state) == S_READ))
    else $error("stray request RAM capture");

  // only the final word of a reply may be short
  a_short_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_bytes != 3'd4) |-> rsp_last)
    else $error("short word not marked last");

  // byte count of a word is 1 to 4
  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_bytes != 3'd0 && rsp_bytes <= 3'd4))
    else $error("bad word byte count");

endmodule

`default_nettype wire

FILE: tb/sv/ir_gamepad_accessory_responder_unit_test.sv
`timescale 1ns / 100ps

module ir_gamepad_accessory_responder_unit_test;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int FROM_MODEL = -1;
  localparam int RANDOM_ITEMS = 185;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;
  localparam int REPORTED_MAX = 10;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         value;
    logic               last;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic               zl;
    logic               zr;
  } req_item_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } rsp_word_t;

  typedef struct packed {
    req_item_t it;
    int        typed_n;
    rsp_word_t w0;
    rsp_word_t w1;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  irgar_req_if req_ch ();
  irgar_rsp_if rsp_ch ();

  ir_gamepad_accessory_responder_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // accessory state as predicted
  logic [7:0]                  pkt_bytes [irgar_pkg::REQ_DEPTH];
  logic [irgar_pkg::CNT_W-1:0] pkt_count;
  logic [7:0]                  period;
  logic [7:0]                  ticks_left;
  logic                        reporting;
  logic [7:0]                  reply_buf [irgar_pkg::CAL_BYTES + irgar_pkg::HDR_LEN];
  rsp_word_t                   reply [$];
  rsp_word_t                   pending_words [$];
  dir_row_t                    dir_rows [$];
  logic [7:0]                  pkt_buf [10];

  int fails = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int burst_left = 1;

  function automatic void pack_reply(input int len);
    int pos;
    int n;
    rsp_word_t r;
    pos = 0;
    while (pos < len) begin
      n = (len - pos > 4) ? 4 : len - pos;
      r = '0;
      for (int k = 0; k < n; k++) r.data[8*k +: 8] = reply_buf[pos + k];
      pos += n;
      r.nbytes = 3'(n);
      r.last = (pos == len);
      reply = {reply, r};
    end
  endfunction

  function automatic void close_packet();
    int offs;
    int size;
    if (pkt_bytes[0] == irgar_pkg::PKT_STATUS) begin
      if (pkt_count == irgar_pkg::STATUS_LEN) begin
        period = pkt_bytes[1];
        ticks_left = pkt_bytes[1];
        reporting = 1'b1;
      end
    end else if (pkt_bytes[0] == irgar_pkg::PKT_CAL && pkt_count == irgar_pkg::CAL_LEN) begin
      offs = int'({pkt_bytes[3], pkt_bytes[2]} & irgar_pkg::ALIGN_MASK);
      size = int'({pkt_bytes[5], pkt_bytes[4]} & irgar_pkg::ALIGN_MASK);
      if (offs + size <= irgar_pkg::CAL_BYTES) begin
        reply_buf[0] = irgar_pkg::RESP_CAL;
        for (int k = 0; k < 4; k++) reply_buf[1 + k] = pkt_bytes[2 + k];
        for (int k = 0; k < size; k++)
          reply_buf[irgar_pkg::HDR_LEN + k] = irgar_pkg::FACTORY_CAL[(offs + k) & 63];
        pack_reply(irgar_pkg::HDR_LEN + size);
      end
    end
  endfunction

  function automatic void status_reply(input req_item_t it);
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] w;
    x = irgar_pkg::STICK_CENTER + 12'(it.sx);
    y = irgar_pkg::STICK_CENTER + 12'(it.sy);
    w = {y, x, irgar_pkg::RESP_STATUS};
    for (int k = 0; k < 4; k++) reply_buf[k] = w[8*k +: 8];
    reply_buf[4] = {1'b1, ~it.zr, ~it.zl, irgar_pkg::BATTERY_FULL};
    reply_buf[5] = 8'h00;
    pack_reply(6);
  endfunction

  // updates the predicted state and leaves the response words in reply
  function automatic void predict_response(input req_item_t it);
    reply.delete();
    case (it.kind)
      irgar_pkg::REQ_BYTE: begin
        if (pkt_count < irgar_pkg::REQ_DEPTH) pkt_bytes[pkt_count] = it.value;
        if (pkt_count < irgar_pkg::CNT_MAX) pkt_count = pkt_count + 1'b1;
        if (it.last) begin
          close_packet();
          pkt_count = '0;
        end
      end
      irgar_pkg::REQ_TICK: begin
        if (reporting) begin
          if (ticks_left <= 8'd1) begin
            ticks_left = period;
            status_reply(it);
          end else begin
            ticks_left = ticks_left - 1'b1;
          end
        end
      end
      irgar_pkg::REQ_DISC: reporting = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic req_item_t mk(input logic [1:0] kind, input logic [7:0] v, input logic l,
                                   input logic signed [11:0] sx, input logic signed [11:0] sy,
                                   input logic zl, input logic zr);
    req_item_t it;
    it.kind = kind;
    it.value = v;
    it.last = l;
    it.sx = sx;
    it.sy = sy;
    it.zl = zl;
    it.zr = zr;
    return it;
  endfunction

  function automatic req_item_t rand_item(input logic [1:0] kind);
    return mk(kind, 8'($urandom), 1'($urandom), 12'($urandom), 12'($urandom),
              1'($urandom), 1'($urandom));
  endfunction

  function automatic rsp_word_t word(input logic [31:0] d, input logic [2:0] nb, input logic l);
    rsp_word_t r;
    r.data = d;
    r.nbytes = nb;
    r.last = l;
    return r;
  endfunction

  // request byte with sticks centered and buttons released
  function automatic req_item_t mk_byte(input logic [7:0] v, input logic l);
    return mk(irgar_pkg::REQ_BYTE, v, l, 12'sd0, 12'sd0, 1'b0, 1'b0);
  endfunction

  task automatic add_row(input req_item_t it, input int typed_n = FROM_MODEL,
                         input rsp_word_t w0 = '0, input rsp_word_t w1 = '0);
    dir_row_t row;
    row.it = it;
    row.typed_n = typed_n;
    row.w0 = w0;
    row.w1 = w1;
    dir_rows = {dir_rows, row};
  endtask

  // present one request, wait for its handshake, queue what it should produce
  task automatic send(input req_item_t it, input int typed_n = FROM_MODEL,
                      input rsp_word_t w0 = '0, input rsp_word_t w1 = '0);
    int gap;
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= it.kind;
    req_ch.byte_value <= it.value;
    req_ch.byte_last  <= it.last;
    req_ch.stick_x    <= it.sx;
    req_ch.stick_y    <= it.sy;
    req_ch.zl_pressed <= it.zl;
    req_ch.zr_pressed <= it.zr;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_response(it);
    if (typed_n == FROM_MODEL) begin
      foreach (reply[i]) pending_words = {pending_words, reply[i]};
    end else begin
      if (typed_n > 0) pending_words = {pending_words, w0};
      if (typed_n > 1) pending_words = {pending_words, w1};
    end
    if (it.kind != REQ_UNUSED) sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
  endtask

  // bytes of pkt_buf, now and then broken up by a tick or a disconnect
  task automatic send_packet(input int len);
    req_item_t it;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 11) == 0)
        send(rand_item($urandom_range(0, 1) ? irgar_pkg::REQ_TICK : irgar_pkg::REQ_DISC));
      it = rand_item(irgar_pkg::REQ_BYTE);
      it.value = pkt_buf[i];
      it.last = (i == len - 1);
      send(it);
    end
  endtask

  // receiver: stall style changes every so often
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom);
        2: rsp_ch.ready <= (cycle_count % 3 != 0);
        default: begin
          if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
          end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_left <= $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    rsp_word_t exp_w;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        fails++;
        if (fails <= REPORTED_MAX)
          $display("unexpected response word: data %h bytes %0d last %0b",
                   rsp_ch.out_data, rsp_ch.out_bytes, rsp_ch.out_last);
      end else begin
        exp_w = pending_words.pop_front();
        if (rsp_ch.out_data !== exp_w.data || rsp_ch.out_bytes !== exp_w.nbytes ||
            rsp_ch.out_last !== exp_w.last) begin
          fails++;
          if (fails <= REPORTED_MAX)
            $display("response mismatch: data %h (exp %h) bytes %0d (exp %0d) last %0b (exp %0b)",
                     rsp_ch.out_data, exp_w.data, rsp_ch.out_bytes, exp_w.nbytes,
                     rsp_ch.out_last, exp_w.last);
        end
      end
    end
  end

  initial begin
    int p;
    int target;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = irgar_pkg::REQ_BYTE;
    req_ch.byte_value = 8'h00;
    req_ch.byte_last = 1'b0;
    req_ch.stick_x = '0;
    req_ch.stick_y = '0;
    req_ch.zl_pressed = 1'b0;
    req_ch.zr_pressed = 1'b0;
    rsp_ch.ready = 1'b0;
    foreach (pkt_bytes[i]) pkt_bytes[i] = 8'h00;
    pkt_count = '0;
    period = 8'h00;
    ticks_left = 8'h00;
    reporting = 1'b0;

    // tick right after reset: reports are off
    add_row(mk(irgar_pkg::REQ_TICK, 8'h00, 1'b0, 12'sd0, 12'sd0, 1'b0, 1'b0), 0);
    add_row(mk(REQ_UNUSED, 8'hFF, 1'b1, 12'sd0, 12'sd0, 1'b1, 1'b1), 0);
    // status every tick, then stick and button extremes
    add_row(mk_byte(irgar_pkg::PKT_STATUS, 1'b0));
    add_row(mk_byte(8'h01, 1'b0));
    add_row(mk_byte(8'h00, 1'b1), 0);
    add_row(mk(irgar_pkg::REQ_TICK, 8'h00, 1'b0, 12'sd2047, -12'sd2048, 1'b0, 1'b0), 2,
            word(32'h000FFF10, 3'd4, 1'b0), word(32'h000000FF, 3'd2, 1'b1));
    add_row(mk(irgar_pkg::REQ_TICK, 8'h00, 1'b0, -12'sd2048, 12'sd2047, 1'b1, 1'b1), 2,
            word(32'hFFF00010, 3'd4, 1'b0), word(32'h0000009F, 3'd2, 1'b1));
    add_row(mk(irgar_pkg::REQ_DISC, 8'h00, 1'b0, 12'sd0, 12'sd0, 1'b0, 1'b0), 0);
    add_row(mk(irgar_pkg::REQ_TICK, 8'h00, 1'b0, 12'sd5, 12'sd5, 1'b0, 1'b0), 0);
    // zero size after alignment: header only
    add_row(mk_byte(irgar_pkg::PKT_CAL, 1'b0));
    add_row(mk_byte(8'h00, 1'b0));
    add_row(mk_byte(8'h0F, 1'b0));
    add_row(mk_byte(8'h00, 1'b0));
    add_row(mk_byte(8'h0F, 1'b0));
    add_row(mk_byte(8'h00, 1'b1), 2,
            word(32'h0F000F11, 3'd4, 1'b0), word(32'h00000000, 3'd1, 1'b1));
    // offset and size at their maximum: out of range
    add_row(mk_byte(irgar_pkg::PKT_CAL, 1'b0));
    for (int i = 0; i < 4; i++)
      add_row(mk_byte(8'hFF, 1'b0));
    add_row(mk_byte(8'hFF, 1'b1), 0);
    // whole table: longest reply
    add_row(mk_byte(irgar_pkg::PKT_CAL, 1'b0));
    add_row(mk_byte(8'h00, 1'b0));
    add_row(mk_byte(8'h00, 1'b0));
    add_row(mk_byte(8'h00, 1'b0));
    add_row(mk_byte(8'h40, 1'b0));
    add_row(mk_byte(8'h00, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send(dir_rows[i].it, dir_rows[i].typed_n, dir_rows[i].w0, dir_rows[i].w1);

    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      p = $urandom_range(0, 99);
      if (p < 35) begin
        pkt_buf[0] = irgar_pkg::PKT_STATUS;
        pkt_buf[1] = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        pkt_buf[2] = 8'($urandom);
        send_packet(3);
      end else if (p < 65) begin
        pkt_buf[0] = irgar_pkg::PKT_CAL;
        pkt_buf[1] = 8'($urandom);
        pkt_buf[2] = {4'($urandom_range(0, 3)), 4'($urandom)};
        pkt_buf[3] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
        pkt_buf[4] = {4'($urandom_range(0, 4)), 4'($urandom)};
        pkt_buf[5] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
        send_packet(6);
      end else if (p < 88) begin
        repeat ($urandom_range(1, 6)) send(rand_item(irgar_pkg::REQ_TICK));
      end else if (p < 93) begin
        send(rand_item(irgar_pkg::REQ_DISC));
      end else if (p < 98) begin
        // wrong length, unknown type, or too many bytes
        case ($urandom_range(0, 2))
          0: pkt_buf[0] = irgar_pkg::PKT_STATUS;
          1: pkt_buf[0] = irgar_pkg::PKT_CAL;
          default: pkt_buf[0] = 8'($urandom);
        endcase
        for (int i = 1; i < 10; i++) pkt_buf[i] = 8'($urandom);
        send_packet($urandom_range(1, 9));
      end else begin
        send(rand_item(REQ_UNUSED));
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) fails++;

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
